FILE: rtl/mrc_pkg.sv
// Shared types, codes and the CRC-16 byte step for the Modbus RTU reply checker.
`timescale 1ns / 1ps

package mrc_pkg;

	// Input modes
	localparam logic [1:0] MODE_ARM  = 2'd0;
	localparam logic [1:0] MODE_BYTE = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Function codes
	localparam logic [7:0] FC_READ_COILS = 8'h01;
	localparam logic [7:0] FC_READ_REGS  = 8'h03;
	localparam logic [7:0] FC_WRITE_COIL = 8'h05;
	localparam logic [7:0] FC_WRITE_REG  = 8'h06;
	localparam logic [7:0] FC_WRITE_MULT = 8'h10;

	// Verdict codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_RESP    = 3'd1;
	localparam logic [2:0] ST_BAD_CRC     = 3'd2;
	localparam logic [2:0] ST_TIMEOUT     = 3'd3;
	localparam logic [2:0] ST_INVALID_ARG = 3'd4;

	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [15:0] TIMEOUT_RESET = 16'd250;
	localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
	localparam logic [7:0]  COIL_ON_BYTE  = 8'hFF;
	localparam logic [7:0]  WRITE_FRAME_LEN = 8'd8;
	localparam logic [7:0]  READ_OVERHEAD   = 8'd5;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Request classes decided by the front end
	typedef enum logic [2:0] {
		K_NONE,
		K_ARM_BAD,
		K_ARM_BCAST,
		K_ARM,
		K_BYTE,
		K_TICK
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  slave;
		logic [7:0]  fc;
		logic [15:0] start;
		logic [15:0] cv;
		logic [7:0]  frame_len;
		logic [7:0]  payload_len;
		logic [7:0]  rx_byte;
	} item_t;

	// One reflected CRC-16 byte step, low bit first
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

FILE: rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU master reply checker: front end, queue, back end, timeout register.
`timescale 1ns / 1ps
// Path: an accepted request is written into the queue, then handled by the back end, and
//   any result it gives is registered in the output register; requests wait in the queue
//   while the output stalls.
// Throughput: one request per cycle while the queue is not full; the back end retires one
//   request a cycle unless the output stalls, set by the combinational CRC-16 byte step and header compare.
// Reset (arst_n low, asynchronous): empties the queue, disarms, drops any pending result
//   and loads the reply timeout with 250 ticks.

module modbus_rtu_response_checker #(
	parameter int MAX_REGS  = 64,
	parameter int MAX_COILS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  slave_addr,
	input  logic [7:0]  function_code,
	input  logic [15:0] start_addr,
	input  logic [15:0] count_or_value,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] data_word,
	output logic [5:0]  word_index,
	output logic [2:0]  status,
	output logic        last,
	// timeout register write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic           q_push;
	logic           q_ready;
	logic           q_pop;
	logic           q_valid;
	mrc_pkg::item_t front_item;
	mrc_pkg::item_t back_item;
	logic [15:0]    timeout_q;

	// The timeout register always takes a write; the user must change it only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= mrc_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	// Classify each request: bad arguments and broadcast register writes (function 06) are marked here,
	// and the frame length of an arm request is worked out ahead of the back end.
	mrc_front #(
		.MAX_REGS  (MAX_REGS),
		.MAX_COILS (MAX_COILS)
	) u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.slave_addr     (slave_addr),
		.function_code  (function_code),
		.start_addr     (start_addr),
		.count_or_value (count_or_value),
		.rx_byte        (rx_byte),
		.q_ready        (q_ready),
		.push           (q_push),
		.item           (front_item)
	);

	// Hold classified requests so that the front end keeps accepting, until the queue is full, while the
	// result side stalls.
	mrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (front_item),
		.push_ready (q_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_item   (back_item)
	);

	// Advance the reply state one request a cycle while the output does not stall, and register each result.
	mrc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_q),
		.q_valid       (q_valid),
		.q_item        (back_item),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_word     (data_word),
		.word_index    (word_index),
		.status        (status),
		.last          (last)
	);

endmodule

FILE: rtl/mrc_front.sv
// Front end: classifies each request and works out the expected frame length.
`timescale 1ns / 1ps

module mrc_front #(
	parameter int MAX_REGS  = 64,
	parameter int MAX_COILS = 16
) (
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [7:0]         slave_addr,
	input  logic [7:0]         function_code,
	input  logic [15:0]        start_addr,
	input  logic [15:0]        count_or_value,
	input  logic [7:0]         rx_byte,
	input  logic               q_ready,
	output logic               push,
	output mrc_pkg::item_t     item
);

	logic       bad_arg;
	logic [5:0] coil_bytes;

	assign in_ready   = q_ready;
	assign coil_bytes = (6'(count_or_value[4:0]) + 6'd7) >> 3;

	always_comb begin
		unique case (function_code)
			mrc_pkg::FC_READ_COILS:
				bad_arg = (count_or_value == 16'd0) || (count_or_value > 16'(MAX_COILS));
			mrc_pkg::FC_READ_REGS, mrc_pkg::FC_WRITE_MULT:
				bad_arg = (count_or_value == 16'd0) || (count_or_value > 16'(MAX_REGS));
			mrc_pkg::FC_WRITE_COIL, mrc_pkg::FC_WRITE_REG:
				bad_arg = 1'b0;
			default:
				bad_arg = 1'b1;
		endcase
	end

	always_comb begin
		item.slave   = slave_addr;
		item.fc      = function_code;
		item.start   = start_addr;
		item.cv      = count_or_value;
		item.rx_byte = rx_byte;
		if (function_code == mrc_pkg::FC_READ_COILS) begin
			item.payload_len = 8'(coil_bytes);
		end else if (function_code == mrc_pkg::FC_READ_REGS) begin
			item.payload_len = {count_or_value[6:0], 1'b0};
		end else begin
			item.payload_len = 8'd0;
		end
		if (function_code == mrc_pkg::FC_READ_COILS
				|| function_code == mrc_pkg::FC_READ_REGS) begin
			item.frame_len = mrc_pkg::READ_OVERHEAD + item.payload_len;
		end else begin
			item.frame_len = mrc_pkg::WRITE_FRAME_LEN;
		end
		unique case (mode)
			mrc_pkg::MODE_ARM: begin
				if (bad_arg) begin
					item.kind = mrc_pkg::K_ARM_BAD;
				end else if (function_code == mrc_pkg::FC_WRITE_REG && slave_addr == 8'd0) begin
					item.kind = mrc_pkg::K_ARM_BCAST;
				end else begin
					item.kind = mrc_pkg::K_ARM;
				end
			end
			mrc_pkg::MODE_BYTE: item.kind = mrc_pkg::K_BYTE;
			mrc_pkg::MODE_TICK: item.kind = mrc_pkg::K_TICK;
			default:            item.kind = mrc_pkg::K_NONE;
		endcase
	end

	// Drop unused modes here so they never occupy the queue
	assign push = in_valid && q_ready && (item.kind != mrc_pkg::K_NONE);

endmodule

FILE: rtl/mrc_queue.sv
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps

module mrc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mrc_pkg::item_t push_item,
	output logic           push_ready,
	input  logic           pop,
	output logic           pop_valid,
	output mrc_pkg::item_t pop_item
);

	mrc_pkg::item_t                 mem_q [mrc_pkg::Q_DEPTH];
	logic [mrc_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [mrc_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [mrc_pkg::Q_CNT_W-1:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = (count_q != mrc_pkg::Q_CNT_W'(mrc_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/mrc_back.sv
// Back end: reply tracking, CRC, echo check, timeout and the output register.
`timescale 1ns / 1ps

module mrc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    timeout_ticks,
	input  logic           q_valid,
	input  mrc_pkg::item_t q_item,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    data_word,
	output logic [5:0]     word_index,
	output logic [2:0]     status,
	output logic           last
);

	logic        armed_q, armed_d;
	logic [7:0]  exp_slave_q, exp_slave_d;
	logic [7:0]  exp_fc_q, exp_fc_d;
	logic [15:0] exp_start_q, exp_start_d;
	logic [15:0] exp_cv_q, exp_cv_d;
	logic [7:0]  frame_len_q, frame_len_d;
	logic [7:0]  payload_len_q, payload_len_d;
	logic [7:0]  byte_pos_q, byte_pos_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_low_q, crc_low_d;
	logic        mismatch_q, mismatch_d;
	logic [7:0]  high_hold_q, high_hold_d;
	logic [15:0] coil_mask_q, coil_mask_d;
	logic [15:0] ticks_q, ticks_d;

	logic        out_valid_q;
	logic [15:0] data_word_q;
	logic [5:0]  word_index_q;
	logic [2:0]  status_q;
	logic        last_q;

	logic        res_valid;
	logic [15:0] res_word;
	logic [5:0]  res_index;
	logic [2:0]  res_status;
	logic        res_last;

	logic [15:0] ticks_inc;
	logic [15:0] crc_next;
	logic [7:0]  want;
	logic        check_hdr;
	logic [7:0]  k;
	logic        crc_bad;
	logic        is_read;
	logic        is_single_write;
	logic [7:0]  b;

	assign pop             = q_valid && (!out_valid_q || out_ready);
	assign b               = q_item.rx_byte;
	assign crc_next        = mrc_pkg::crc_update(crc_q, b);
	assign ticks_inc       = (ticks_q != mrc_pkg::TICKS_MAX) ? ticks_q + 16'd1 : ticks_q;
	assign k               = byte_pos_q - 8'd3;
	assign is_read         = (exp_fc_q == mrc_pkg::FC_READ_COILS)
	                         || (exp_fc_q == mrc_pkg::FC_READ_REGS);
	assign is_single_write = (exp_fc_q == mrc_pkg::FC_WRITE_COIL)
	                         || (exp_fc_q == mrc_pkg::FC_WRITE_REG);
	assign crc_bad         = (crc_low_q != crc_q[7:0]) || (b != crc_q[15:8]);

	// Expected header or echo byte at the current position
	always_comb begin
		want      = 8'd0;
		check_hdr = 1'b1;
		case (byte_pos_q)
			8'd0: want = exp_slave_q;
			8'd1: want = exp_fc_q;
			8'd2: want = is_read ? payload_len_q : exp_start_q[15:8];
			8'd3: want = exp_start_q[7:0];
			8'd4: begin
				if (exp_fc_q == mrc_pkg::FC_WRITE_COIL) begin
					want = (exp_cv_q != 16'd0) ? mrc_pkg::COIL_ON_BYTE : 8'd0;
				end else begin
					want = exp_cv_q[15:8];
				end
			end
			8'd5: want = (exp_fc_q == mrc_pkg::FC_WRITE_COIL) ? 8'd0 : exp_cv_q[7:0];
			default: check_hdr = 1'b0;
		endcase
		if (is_read && byte_pos_q > 8'd2) begin
			check_hdr = 1'b0;
		end
	end

	always_comb begin
		armed_d       = armed_q;
		exp_slave_d   = exp_slave_q;
		exp_fc_d      = exp_fc_q;
		exp_start_d   = exp_start_q;
		exp_cv_d      = exp_cv_q;
		frame_len_d   = frame_len_q;
		payload_len_d = payload_len_q;
		byte_pos_d    = byte_pos_q;
		crc_d         = crc_q;
		crc_low_d     = crc_low_q;
		mismatch_d    = mismatch_q;
		high_hold_d   = high_hold_q;
		coil_mask_d   = coil_mask_q;
		ticks_d       = ticks_q;
		res_valid     = 1'b0;
		res_word      = 16'd0;
		res_index     = 6'd0;
		res_status    = mrc_pkg::ST_OK;
		res_last      = 1'b1;
		if (pop) begin
			unique case (q_item.kind)
				mrc_pkg::K_ARM_BAD: begin
					armed_d    = 1'b0;
					res_valid  = 1'b1;
					res_status = mrc_pkg::ST_INVALID_ARG;
				end
				mrc_pkg::K_ARM_BCAST: begin
					armed_d   = 1'b0;
					res_valid = 1'b1;
				end
				mrc_pkg::K_ARM: begin
					armed_d       = 1'b1;
					exp_slave_d   = q_item.slave;
					exp_fc_d      = q_item.fc;
					exp_start_d   = q_item.start;
					exp_cv_d      = q_item.cv;
					frame_len_d   = q_item.frame_len;
					payload_len_d = q_item.payload_len;
					byte_pos_d    = 8'd0;
					crc_d         = mrc_pkg::CRC_SEED;
					crc_low_d     = 8'd0;
					mismatch_d    = 1'b0;
					high_hold_d   = 8'd0;
					coil_mask_d   = 16'd0;
					ticks_d       = 16'd0;
				end
				mrc_pkg::K_TICK: begin
					if (armed_q) begin
						ticks_d = ticks_inc;
						if (ticks_inc >= timeout_ticks) begin
							armed_d    = 1'b0;
							res_valid  = 1'b1;
							res_status = mrc_pkg::ST_TIMEOUT;
						end
					end
				end
				mrc_pkg::K_BYTE: begin
					if (armed_q) begin
						if (byte_pos_q + 8'd1 == frame_len_q) begin
							armed_d   = 1'b0;
							res_valid = 1'b1;
							if (mismatch_q) begin
								res_status = mrc_pkg::ST_BAD_RESP;
							end else if (crc_bad) begin
								res_status = is_single_write ? mrc_pkg::ST_BAD_RESP
								                             : mrc_pkg::ST_BAD_CRC;
							end else if (exp_fc_q == mrc_pkg::FC_READ_COILS) begin
								res_word = coil_mask_q;
							end
						end else begin
							byte_pos_d = byte_pos_q + 8'd1;
							if (byte_pos_q + 8'd2 == frame_len_q) begin
								crc_low_d = b;
							end else begin
								crc_d = crc_next;
								if (check_hdr && b != want) begin
									mismatch_d = 1'b1;
								end
								if (byte_pos_q >= 8'd3) begin
									if (exp_fc_q == mrc_pkg::FC_READ_COILS) begin
										if (k == 8'd0) begin
											coil_mask_d = {coil_mask_q[15:8], b};
										end else begin
											coil_mask_d = {b, coil_mask_q[7:0]};
										end
									end else if (exp_fc_q == mrc_pkg::FC_READ_REGS) begin
										if (!k[0]) begin
											high_hold_d = b;
										end else begin
											res_valid = 1'b1;
											res_last  = 1'b0;
											res_word  = {high_hold_q, b};
											res_index = k[6:1];
										end
									end
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			exp_slave_q   <= 8'd0;
			exp_fc_q      <= 8'd0;
			exp_start_q   <= 16'd0;
			exp_cv_q      <= 16'd0;
			frame_len_q   <= 8'd0;
			payload_len_q <= 8'd0;
			byte_pos_q    <= 8'd0;
			crc_q         <= mrc_pkg::CRC_SEED;
			crc_low_q     <= 8'd0;
			mismatch_q    <= 1'b0;
			high_hold_q   <= 8'd0;
			coil_mask_q   <= 16'd0;
			ticks_q       <= 16'd0;
			out_valid_q   <= 1'b0;
		end else begin
			armed_q       <= armed_d;
			exp_slave_q   <= exp_slave_d;
			exp_fc_q      <= exp_fc_d;
			exp_start_q   <= exp_start_d;
			exp_cv_q      <= exp_cv_d;
			frame_len_q   <= frame_len_d;
			payload_len_q <= payload_len_d;
			byte_pos_q    <= byte_pos_d;
			crc_q         <= crc_d;
			crc_low_q     <= crc_low_d;
			mismatch_q    <= mismatch_d;
			high_hold_q   <= high_hold_d;
			coil_mask_q   <= coil_mask_d;
			ticks_q       <= ticks_d;
			if (res_valid) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			data_word_q  <= res_word;
			word_index_q <= res_index;
			status_q     <= res_status;
			last_q       <= res_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign data_word  = data_word_q;
	assign word_index = word_index_q;
	assign status     = status_q;
	assign last       = last_q;

	a_tentative_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> status_q == mrc_pkg::ST_OK)
		else $error("tentative word carries a verdict code");

	a_verdict_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_last |=> !armed_q)
		else $error("still armed after a verdict");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> byte_pos_q < frame_len_q)
		else $error("byte position ran past the frame");

	a_verdict_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_q |-> word_index_q == 6'd0)
		else $error("verdict carries a word index");

endmodule
